// ===== rtl/u8dv_pkg.sv =====
// ----------------------------------------------------------------------------
// u8dv_pkg
// Shared types, constants and lead-byte decode helpers for the UTF-8
// character decoder and validator.
// ----------------------------------------------------------------------------
package u8dv_pkg;

  localparam int NUM_LANES = 5;          // continuation bytes byte1..byte5
  localparam int CP_W      = 31;         // code point width

  localparam logic [2:0] AVAIL_SAT = 3'd6;
  localparam logic [2:0] LEN_NONE  = 3'd0;

  localparam logic [7:0] CONT_LO   = 8'h80;
  localparam logic [7:0] CONT_HI   = 8'hBF;

  // Lead bytes with tightened second-byte bounds
  localparam logic [7:0] LEAD_E0   = 8'hE0;
  localparam logic [7:0] LEAD_ED   = 8'hED;
  localparam logic [7:0] LEAD_F0   = 8'hF0;
  localparam logic [7:0] LEAD_F8   = 8'hF8;
  localparam logic [7:0] LEAD_FC   = 8'hFC;

  localparam logic [7:0] SEC_LO_E0 = 8'hA0;
  localparam logic [7:0] SEC_HI_ED = 8'h9F;
  localparam logic [7:0] SEC_LO_F0 = 8'h90;
  localparam logic [7:0] SEC_LO_F8 = 8'h88;
  localparam logic [7:0] SEC_LO_FC = 8'h84;

  typedef struct packed {
    logic       in_range;
    logic [5:0] bits;
  } lane_res_t;

  typedef lane_res_t [NUM_LANES-1:0] lane_vec_t;

  typedef struct packed {
    logic            is_legal;
    logic [2:0]      bytes_used;
    logic [CP_W-1:0] code_point;
  } dec_res_t;

  // Sequence length from the lead byte; zero marks an illegal lead.
  function automatic logic [2:0] lead_len(input logic [7:0] b);
    logic [2:0] len;
    if (b < 8'h80)      len = 3'd1;
    else if (b < 8'hC2) len = LEN_NONE;
    else if (b < 8'hE0) len = 3'd2;
    else if (b < 8'hF0) len = 3'd3;
    else if (b < 8'hF8) len = 3'd4;
    else if (b < 8'hFC) len = 3'd5;
    else if (b < 8'hFE) len = 3'd6;
    else                len = LEN_NONE;
    return len;
  endfunction

  function automatic logic [7:0] sec_lo(input logic [7:0] lead);
    logic [7:0] lo;
    unique case (lead)
      LEAD_E0: lo = SEC_LO_E0;
      LEAD_F0: lo = SEC_LO_F0;
      LEAD_F8: lo = SEC_LO_F8;
      LEAD_FC: lo = SEC_LO_FC;
      default: lo = CONT_LO;
    endcase
    return lo;
  endfunction

  function automatic logic [7:0] sec_hi(input logic [7:0] lead);
    logic [7:0] hi;
    unique case (lead)
      LEAD_ED: hi = SEC_HI_ED;
      default: hi = CONT_HI;
    endcase
    return hi;
  endfunction

endpackage

// ===== rtl/utf8_char_decoder_validator_unit.sv =====
// ----------------------------------------------------------------------------
// utf8_char_decoder_validator_unit
// Pipeline: input beat -> lane stage registers -> merge stage registers -> result beat.
// Throughput: one window per cycle while out_ready holds; each stage advances on its
// own enable, so an empty lane stage takes a new beat while a result waits at the output.
// Reset: synchronous, active low; clears the stage valid flags only.
// ----------------------------------------------------------------------------
// Decodes and checks the first character (legacy 1..6 byte form) of a
// six-byte window. Five lanes check byte1..byte5 in parallel and extract
// their payload bits; a merge stage decodes the lead byte, gates the lane
// checks by sequence length and assembles the code point.
// ----------------------------------------------------------------------------
module utf8_char_decoder_validator_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte0,
  input  logic [7:0]  in_byte1,
  input  logic [7:0]  in_byte2,
  input  logic [7:0]  in_byte3,
  input  logic [7:0]  in_byte4,
  input  logic [7:0]  in_byte5,
  input  logic [2:0]  in_bytes_available,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_is_legal,
  output logic [2:0]  out_bytes_used,
  output logic [30:0] out_code_point
);

  // Continuation bytes in lane order
  logic [u8dv_pkg::NUM_LANES-1:0][7:0] cont_bytes;
  assign cont_bytes = {in_byte5, in_byte4, in_byte3, in_byte2, in_byte1};

  // ---------------------------------------------------------- stage 1 regs
  logic                s1_valid_r, s1_valid_nxt;
  logic [7:0]          s1_lead_r;
  logic [2:0]          s1_avail_r;
  u8dv_pkg::lane_vec_t s1_lanes_r;

  // Stage enables: each stage loads when it is empty or its consumer moves
  logic s2_en;
  logic s1_en;
  assign s2_en    = !out_valid || out_ready;
  assign s1_en    = !s1_valid_r || s2_en;
  assign in_ready = s1_en;

  // ---------------------------------------------------------------- lanes
  u8dv_pkg::lane_vec_t lanes;

  for (genvar k = 0; k < u8dv_pkg::NUM_LANES; k++) begin : g_lane
    logic [7:0] lo;
    logic [7:0] hi;
    if (k == 0) begin : g_second
      // second byte bounds depend on the lead byte
      assign lo = u8dv_pkg::sec_lo(in_byte0);
      assign hi = u8dv_pkg::sec_hi(in_byte0);
    end else begin : g_cont
      assign lo = u8dv_pkg::CONT_LO;
      assign hi = u8dv_pkg::CONT_HI;
    end
    u8dv_lane u_lane (
      .byte_i (cont_bytes[k]),
      .lo_i   (lo),
      .hi_i   (hi),
      .res_o  (lanes[k])
    );
  end

  // Saturate the byte count at six
  logic [2:0] avail_sat;
  assign avail_sat = (in_bytes_available > u8dv_pkg::AVAIL_SAT) ?
                     u8dv_pkg::AVAIL_SAT : in_bytes_available;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (s1_en) begin
      s1_valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  // payload: load on accepted beat, hold otherwise
  always_ff @(posedge clk) begin
    if (s1_en && in_valid) begin
      s1_lead_r  <= in_byte0;
      s1_avail_r <= avail_sat;
      s1_lanes_r <= lanes;
    end
  end

  // ---------------------------------------------------------------- merge
  u8dv_pkg::dec_res_t merged;

  u8dv_merge u_merge (
    .lead_i  (s1_lead_r),
    .avail_i (s1_avail_r),
    .lanes_i (s1_lanes_r),
    .res_o   (merged)
  );

  // --------------------------------------------------------- output regs
  logic               out_valid_r, out_valid_nxt;
  u8dv_pkg::dec_res_t out_res_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s2_en) begin
      out_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_en && s1_valid_r) begin
      out_res_r <= merged;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_is_legal   = out_res_r.is_legal;
  assign out_bytes_used = out_res_r.bytes_used;
  assign out_code_point = out_res_r.code_point;

  // ----------------------------------------------------------- assertions
  // An accepted beat always lands in the lane stage
  a_accept_to_s1: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> s1_valid_r)
    else $error("accepted beat not captured in lane stage");

  // A full lane stage with an open output moves to the output
  a_s1_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s2_en) |=> out_valid)
    else $error("lane stage beat lost on its way to output");

  // An illegal result carries zero length and zero code point
  a_illegal_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_is_legal) |-> (out_bytes_used == 3'd0 && out_code_point == 31'd0))
    else $error("illegal result with nonzero fields");

  // A legal result has a length in range and a one-byte form stays ASCII
  a_legal_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_is_legal) |->
      (out_bytes_used != 3'd0 && out_bytes_used != 3'd7 &&
       (out_bytes_used != 3'd1 || out_code_point[30:7] == 24'd0)))
    else $error("legal result with bad length or code point");

endmodule

// ===== rtl/u8dv_lane.sv =====
// ----------------------------------------------------------------------------
// u8dv_lane
// One continuation-byte lane: range check and payload bit extraction.
// ----------------------------------------------------------------------------
module u8dv_lane (
  input  logic [7:0]          byte_i,
  input  logic [7:0]          lo_i,
  input  logic [7:0]          hi_i,
  output u8dv_pkg::lane_res_t res_o
);

  assign res_o.in_range = (byte_i >= lo_i) && (byte_i <= hi_i);
  assign res_o.bits     = byte_i[5:0];

endmodule

// ===== rtl/u8dv_merge.sv =====
// ----------------------------------------------------------------------------
// u8dv_merge
// Combine lead decode and lane results into legality, length and code point.
// ----------------------------------------------------------------------------
module u8dv_merge (
  input  logic [7:0]          lead_i,
  input  logic [2:0]          avail_i,
  input  u8dv_pkg::lane_vec_t lanes_i,
  output u8dv_pkg::dec_res_t  res_o
);

  logic [2:0]                len;
  logic                      ok;
  logic [u8dv_pkg::CP_W-1:0] cp;

  always_comb begin
    len = u8dv_pkg::lead_len(lead_i);
    ok  = (avail_i != 3'd0) && (len != u8dv_pkg::LEN_NONE) && (len <= avail_i);
    // only lanes inside the sequence count
    for (int k = 0; k < u8dv_pkg::NUM_LANES; k++) begin
      if ((len > 3'(k + 1)) && !lanes_i[k].in_range) begin
        ok = 1'b0;
      end
    end
  end

  always_comb begin
    case (len)
      3'd1: cp = {24'd0, lead_i[6:0]};
      3'd2: cp = {20'd0, lead_i[4:0], lanes_i[0].bits};
      3'd3: cp = {15'd0, lead_i[3:0], lanes_i[0].bits, lanes_i[1].bits};
      3'd4: cp = {10'd0, lead_i[2:0], lanes_i[0].bits, lanes_i[1].bits,
                  lanes_i[2].bits};
      3'd5: cp = {5'd0, lead_i[1:0], lanes_i[0].bits, lanes_i[1].bits,
                  lanes_i[2].bits, lanes_i[3].bits};
      3'd6: cp = {lead_i[0], lanes_i[0].bits, lanes_i[1].bits,
                  lanes_i[2].bits, lanes_i[3].bits, lanes_i[4].bits};
      default: cp = '0;
    endcase
  end

  assign res_o.is_legal   = ok;
  assign res_o.bytes_used = ok ? len : u8dv_pkg::LEN_NONE;
  assign res_o.code_point = ok ? cp : '0;

endmodule
